/* hdl/dssa_pkg.sv */
// Package for the dual stack block: operation codes, result status codes and beat widths.
// It has no dependencies; the top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package dssa_pkg;

    // Width of one stored element and of the pushed and returned data
    localparam int DATA_W   = 32;
    // Width of the size fields in a result beat
    localparam int SIZE_W   = 10;
    // Result tdata: data, size_a, size_b, padded to whole bytes
    localparam int RES_W    = DATA_W + 2 * SIZE_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    // Operation selector carried in the input tuser
    typedef enum logic [2:0] {
        OP_PUSH_A = 3'd0,
        OP_PUSH_B = 3'd1,
        OP_POP_A  = 3'd2,
        OP_POP_B  = 3'd3,
        OP_MOVE_BA = 3'd4,
        OP_MOVE_AB = 3'd5,
        OP_ROT_A  = 3'd6,
        OP_MIN_A  = 3'd7
    } op_t;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

endpackage

`default_nettype wire

/* hdl/dual_stack_shared_array_top.sv */
// One operation is worked on at a time. Rotate and minimum of stack A walk over every
// element of stack A through the single read port of the element memory, so their run
// time grows with size_a.
// The output register lets a new operation start while a result beat waits.
// Reset clears both stack sizes and the handshake state; memory contents are kept.
`timescale 1ns / 1ps
`default_nettype none

// Two signed stacks in one single-port-read, single-port-write memory.
// Depends on dssa_pkg.
module dual_stack_shared_array_top #(
    parameter int DEPTH = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // value (bits 31:0)
    input  wire logic [dssa_pkg::DATA_W-1:0]   s_axis_tdata,
    // opcode (bits 2:0)
    input  wire logic [2:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // data (31:0), size_a (41:32), size_b (51:42), zero (55:52)
    output logic [dssa_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // status (bits 1:0)
    output logic [1:0]                         m_axis_tuser
);

    import dssa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_XFER,
        S_ROT_TOP,
        S_ROT_LOAD,
        S_ROT_MOVE,
        S_ROT_LAST,
        S_MIN_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    status_t             status_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   top_reg;
    logic [CW-1:0]       count_a_reg;
    logic [CW-1:0]       count_b_reg;
    logic [CW-1:0]       ptr_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [1:0]          m_user_reg;

    // Element memory
    logic [DATA_W-1:0]   stack_mem [DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data;

    logic                accept;
    logic                full;
    op_t                 in_op;
    logic                out_free;
    logic [CW-1:0]       top_a_addr;
    logic [CW-1:0]       top_b_addr;
    logic [CW-1:0]       next_b_addr;

    assign in_op       = op_t'(s_axis_tuser);
    assign accept      = s_axis_tvalid && s_axis_tready;
    assign full        = ({1'b0, count_a_reg} + {1'b0, count_b_reg}) >= {1'b0, DEPTH_C};
    assign out_free    = !m_valid_reg || m_axis_tready;
    assign top_a_addr  = count_a_reg - ONE_C;
    assign top_b_addr  = DEPTH_C - count_b_reg;
    assign next_b_addr = DEPTH_C - ONE_C - count_b_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Memory port control, decoded from the current state
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = s_axis_tdata;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_PUSH_A:
                        begin
                            wr_en   = !full;
                            wr_addr = count_a_reg[AW-1:0];
                        end
                        OP_PUSH_B:
                        begin
                            wr_en   = !full;
                            wr_addr = next_b_addr[AW-1:0];
                        end
                        OP_POP_A, OP_MOVE_AB:
                        begin
                            rd_en   = (count_a_reg != '0);
                            rd_addr = top_a_addr[AW-1:0];
                        end
                        OP_POP_B, OP_MOVE_BA:
                        begin
                            rd_en   = (count_b_reg != '0);
                            rd_addr = top_b_addr[AW-1:0];
                        end
                        OP_MIN_A:
                        begin
                            rd_en   = (count_a_reg != '0);
                            rd_addr = '0;
                        end
                        default:
                        begin
                            rd_en = 1'b0;
                        end
                    endcase
                end
            end
            S_XFER:
            begin
                wr_data = rd_data_reg;
                if (op_reg == OP_MOVE_BA)
                begin
                    wr_en   = 1'b1;
                    wr_addr = count_a_reg[AW-1:0];
                end
                else if (op_reg == OP_MOVE_AB)
                begin
                    wr_en   = 1'b1;
                    wr_addr = next_b_addr[AW-1:0];
                end
            end
            S_ROT_TOP:
            begin
                rd_en   = 1'b1;
                rd_addr = top_a_addr[AW-1:0];
            end
            S_ROT_LOAD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(ptr_reg - ONE_C);
            end
            S_ROT_MOVE:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg[AW-1:0];
                wr_data = rd_data_reg;
                if (ptr_reg != ONE_C)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(ptr_reg - CW'(2));
                end
            end
            S_ROT_LAST:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = top_reg;
            end
            S_MIN_SCAN:
            begin
                if (ptr_reg < count_a_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg[AW-1:0];
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Memory with registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // Sequencer, stack sizes and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // A waiting beat leaves unless a new one is loaded in the same cycle
            if (m_valid_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= in_op;
                        case (in_op)
                            OP_PUSH_A:
                            begin
                                data_reg  <= '0;
                                state_reg <= S_DONE;
                                if (full)
                                begin
                                    status_reg <= ST_OVERFLOW;
                                end
                                else
                                begin
                                    status_reg  <= ST_OK;
                                    count_a_reg <= count_a_reg + ONE_C;
                                end
                            end
                            OP_PUSH_B:
                            begin
                                data_reg  <= '0;
                                state_reg <= S_DONE;
                                if (full)
                                begin
                                    status_reg <= ST_OVERFLOW;
                                end
                                else
                                begin
                                    status_reg  <= ST_OK;
                                    count_b_reg <= count_b_reg + ONE_C;
                                end
                            end
                            OP_POP_A, OP_MOVE_AB:
                            begin
                                data_reg <= '0;
                                if (count_a_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    state_reg  <= S_XFER;
                                end
                            end
                            OP_POP_B, OP_MOVE_BA:
                            begin
                                data_reg <= '0;
                                if (count_b_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    state_reg  <= S_XFER;
                                end
                            end
                            OP_ROT_A:
                            begin
                                status_reg <= ST_OK;
                                data_reg   <= '0;
                                if (count_a_reg > ONE_C)
                                begin
                                    state_reg <= S_ROT_TOP;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_MIN_A:
                            begin
                                if (count_a_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    data_reg   <= '0;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    ptr_reg    <= ONE_C;
                                    data_reg   <= MAX_POS;
                                    state_reg  <= S_MIN_SCAN;
                                end
                            end
                            default:
                            begin
                                status_reg <= ST_OK;
                                data_reg   <= '0;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                // Read data is the popped element; a move writes it to the other side
                S_XFER:
                begin
                    data_reg <= rd_data_reg;
                    case (op_reg)
                        OP_POP_A:
                        begin
                            count_a_reg <= count_a_reg - ONE_C;
                        end
                        OP_POP_B:
                        begin
                            count_b_reg <= count_b_reg - ONE_C;
                        end
                        OP_MOVE_BA:
                        begin
                            count_a_reg <= count_a_reg + ONE_C;
                            count_b_reg <= count_b_reg - ONE_C;
                        end
                        OP_MOVE_AB:
                        begin
                            count_a_reg <= count_a_reg - ONE_C;
                            count_b_reg <= count_b_reg + ONE_C;
                        end
                        default:
                        begin
                            count_a_reg <= count_a_reg;
                        end
                    endcase
                    state_reg <= S_DONE;
                end
                // Rotate: fetch the top, shift every other element up by one entry, then write the top to the bottom
                S_ROT_TOP:
                begin
                    ptr_reg   <= top_a_addr;
                    state_reg <= S_ROT_LOAD;
                end
                S_ROT_LOAD:
                begin
                    top_reg   <= rd_data_reg;
                    state_reg <= S_ROT_MOVE;
                end
                S_ROT_MOVE:
                begin
                    if (ptr_reg == ONE_C)
                    begin
                        state_reg <= S_ROT_LAST;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg - ONE_C;
                    end
                end
                S_ROT_LAST:
                begin
                    state_reg <= S_DONE;
                end
                // Minimum: one element arrives per cycle from the read port
                S_MIN_SCAN:
                begin
                    if ($signed(rd_data_reg) < $signed(data_reg))
                    begin
                        data_reg <= rd_data_reg;
                    end
                    if (ptr_reg < count_a_reg)
                    begin
                        ptr_reg <= ptr_reg + ONE_C;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                // Hand the result to the output register once it is free
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= status_reg;
                        m_data_reg  <= M_DATA_W'({SIZE_W'(count_b_reg),
                                                  SIZE_W'(count_a_reg),
                                                  data_reg});
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for dual_stack_shared_array_top: directed and random stack operations
// go through the stream ports and are checked by a class-based predictor. Depends on dssa_pkg.

module tb;
    import dssa_pkg::*;

    localparam int DEPTH       = 512;
    localparam int QUIET_LIMIT = 4000;
    localparam int END_SETTLE  = 600;

    // One expected result beat, split into its fields
    typedef struct {
        status_t     status;
        logic [31:0] data;
        logic [9:0]  size_a;
        logic [9:0]  size_b;
    } op_outcome_t;

    // Scoreboard: mirrors both stacks and queues the expected outcome of every operation.
    class stack_scoreboard;
        logic [31:0]  cells [DEPTH];
        int           cnt_a;
        int           cnt_b;
        op_outcome_t  outcomes_q [$];
        int           errors;
        int           n_checked;
        int           n_overflow;
        int           n_empty;
        int           peak_a;
        int           peak_b;

        function new();
            cnt_a      = 0;
            cnt_b      = 0;
            errors     = 0;
            n_checked  = 0;
            n_overflow = 0;
            n_empty    = 0;
            peak_a     = 0;
            peak_b     = 0;
        endfunction

        function void report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endfunction

        // Works out the outcome of an accepted operation and updates the mirrored stacks.
        function void apply_op(op_t op, logic [31:0] v);
            op_outcome_t        res;
            logic [31:0]        top;
            logic signed [31:0] lowest;
            bit                 full;
            res.status = ST_OK;
            res.data   = '0;
            full       = (cnt_a + cnt_b) >= DEPTH;
            case (op)
                OP_PUSH_A:
                    if (full) res.status = ST_OVERFLOW;
                    else
                    begin
                        cells[cnt_a] = v;
                        cnt_a++;
                    end
                OP_PUSH_B:
                    if (full) res.status = ST_OVERFLOW;
                    else
                    begin
                        cells[DEPTH - 1 - cnt_b] = v;
                        cnt_b++;
                    end
                OP_POP_A:
                    if (cnt_a == 0) res.status = ST_EMPTY;
                    else
                    begin
                        cnt_a--;
                        res.data = cells[cnt_a];
                    end
                OP_POP_B:
                    if (cnt_b == 0) res.status = ST_EMPTY;
                    else
                    begin
                        res.data = cells[DEPTH - cnt_b];
                        cnt_b--;
                    end
                OP_MOVE_BA:
                    if (cnt_b == 0) res.status = ST_EMPTY;
                    else
                    begin
                        res.data = cells[DEPTH - cnt_b];
                        cnt_b--;
                        cells[cnt_a] = res.data;
                        cnt_a++;
                    end
                OP_MOVE_AB:
                    if (cnt_a == 0) res.status = ST_EMPTY;
                    else
                    begin
                        cnt_a--;
                        res.data = cells[cnt_a];
                        cells[DEPTH - 1 - cnt_b] = res.data;
                        cnt_b++;
                    end
                OP_ROT_A:
                    // The top of A drops to the bottom; the rest shift up by one.
                    if (cnt_a > 1)
                    begin
                        top = cells[cnt_a - 1];
                        for (int i = cnt_a - 1; i > 0; i--)
                            cells[i] = cells[i - 1];
                        cells[0] = top;
                    end
                default:
                    if (cnt_a == 0) res.status = ST_EMPTY;
                    else
                    begin
                        lowest = cells[0];
                        for (int i = 1; i < cnt_a; i++)
                            if ($signed(cells[i]) < lowest) lowest = cells[i];
                        res.data = lowest;
                    end
            endcase
            res.size_a = cnt_a[9:0];
            res.size_b = cnt_b[9:0];
            if (cnt_a > peak_a) peak_a = cnt_a;
            if (cnt_b > peak_b) peak_b = cnt_b;
            outcomes_q.push_back(res);
        endfunction

        // Compares one result beat with the oldest outstanding outcome.
        function void check_result(logic [1:0] st, logic [M_DATA_W-1:0] beat);
            op_outcome_t exp;
            if (outcomes_q.size() == 0)
            begin
                report($sformatf("result beat with nothing outstanding, tdata %h", beat));
                return;
            end
            exp = outcomes_q.pop_front();
            n_checked++;
            if (exp.status == ST_OVERFLOW) n_overflow++;
            if (exp.status == ST_EMPTY) n_empty++;
            if (st !== exp.status)
                report($sformatf("status %0d, expected %0d", st, exp.status));
            if (beat[31:0] !== exp.data)
                report($sformatf("data %h, expected %h", beat[31:0], exp.data));
            if (beat[41:32] !== exp.size_a)
                report($sformatf("size_a %0d, expected %0d", beat[41:32], exp.size_a));
            if (beat[51:42] !== exp.size_b)
                report($sformatf("size_b %0d, expected %0d", beat[51:42], exp.size_b));
            if (beat[M_DATA_W-1:52] !== '0)
                report($sformatf("padding bits %h not zero", beat[M_DATA_W-1:52]));
        endfunction

        function int outstanding();
            return outcomes_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata  = '0;
    logic [2:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    stack_scoreboard sb = new();

    int burst_left = 1;
    int rx_mode    = 0;
    int rx_left    = 0;
    int rx_tick    = 0;

    dual_stack_shared_array_top #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: switches between always ready, random stalls and a fixed stall rhythm.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ((rx_tick % 7) < 4);
            default: m_axis_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no beat accepted for %0d cycles.", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Presents one operation, waits until it is accepted, then applies the burst and gap pattern.
    task automatic send_op(op_t op, logic [31:0] v);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        sb.apply_op(op, v);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // Push values lean towards the signed extremes and a narrow band of repeats.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 7) - 4);
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t either_of(op_t x, op_t y);
        return ($urandom_range(0, 1) == 0) ? x : y;
    endfunction

    // Mixed traffic that keeps both stacks short, so empty stacks come up often.
    function automatic op_t pick_shallow_op();
        int r;
        int pw;
        r  = $urandom_range(0, 99);
        pw = (sb.cnt_a + sb.cnt_b < 32) ? 40 : 20;
        if (r < pw) return either_of(OP_PUSH_A, OP_PUSH_B);
        if (r < pw + 25) return either_of(OP_POP_A, OP_POP_B);
        if (r < pw + 40) return either_of(OP_MOVE_BA, OP_MOVE_AB);
        if (r < pw + 50) return OP_ROT_A;
        return OP_MIN_A;
    endfunction

    // Mostly pushes, weighted towards stack A, until the memory is full.
    function automatic op_t pick_fill_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return OP_PUSH_A;
        if (r < 88) return OP_PUSH_B;
        if (r < 92) return either_of(OP_MOVE_BA, OP_MOVE_AB);
        if (r < 94) return either_of(OP_POP_A, OP_POP_B);
        if (r < 97) return OP_MIN_A;
        return OP_ROT_A;
    endfunction

    // Traffic that hovers at full memory: refused pushes, moves, pops and refills.
    function automatic op_t pick_full_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return either_of(OP_PUSH_A, OP_PUSH_B);
        if (r < 60) return either_of(OP_MOVE_BA, OP_MOVE_AB);
        if (r < 80) return either_of(OP_POP_A, OP_POP_B);
        if (r < 90) return OP_MIN_A;
        return OP_ROT_A;
    endfunction

    // Main sequence.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation on empty stacks, single-entry rotate, signed extremes.
        send_op(OP_POP_A, 32'h0);
        send_op(OP_POP_B, 32'h0);
        send_op(OP_MOVE_BA, 32'h0);
        send_op(OP_MOVE_AB, 32'h0);
        send_op(OP_MIN_A, 32'h0);
        send_op(OP_ROT_A, 32'h0);
        send_op(OP_PUSH_A, 32'h7FFF_FFFF);
        send_op(OP_ROT_A, 32'hFFFF_FFFF);
        send_op(OP_MIN_A, 32'hFFFF_FFFF);
        send_op(OP_PUSH_A, 32'h8000_0000);
        send_op(OP_PUSH_A, 32'h0000_0000);
        send_op(OP_PUSH_B, 32'hFFFF_FFFF);
        send_op(OP_PUSH_B, 32'h8000_0000);
        send_op(OP_MIN_A, 32'h0);
        send_op(OP_ROT_A, 32'h0);
        send_op(OP_MIN_A, 32'h0);
        send_op(OP_POP_A, 32'h5555_5555);
        send_op(OP_MOVE_AB, 32'h0);
        send_op(OP_MOVE_BA, 32'h0);
        send_op(OP_POP_B, 32'h0);
        send_op(OP_POP_B, 32'h0);
        send_op(OP_POP_B, 32'h0);
        send_op(OP_POP_A, 32'h0);
        send_op(OP_POP_A, 32'h0);
        drain_results();

        // Random: short stacks with every operation mixed in.
        repeat (460) send_op(pick_shallow_op(), pick_value());
        drain_results();

        // Random: fill the memory, with occasional long walks over stack A.
        while (sb.cnt_a + sb.cnt_b < DEPTH)
            send_op(pick_fill_op(), pick_value());
        drain_results();

        // Random: work at and around the full mark.
        repeat (80) send_op(pick_full_op(), pick_value());

        // Let the last results come out, then allow for any trailing work.
        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));

        $display("Checked %0d results: %0d refused pushes, %0d operations on empty stacks.",
                 sb.n_checked, sb.n_overflow, sb.n_empty);
        $display("Stack A reached %0d entries and stack B %0d.", sb.peak_a, sb.peak_b);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dssa_pkg.sv
hdl/dual_stack_shared_array_top.sv
bench/tb.sv
